### hdl/vbfp_pkg.sv
// ----------------------------------------------------------------------------
// vbfp_pkg: shared types and constants of the frame parser
// Result item layout, register indexes, reason codes and reset values.
// ----------------------------------------------------------------------------
package vbfp_pkg;

  // Default sizes handed to the top level.
  localparam int RECORD_WORDS_DEF = 5;
  localparam int MAX_RECORDS_DEF  = 128;
  localparam int QUEUE_DEPTH      = 2;

  // Configuration register indexes.
  localparam logic REG_MAX_BLOCKS = 1'b0;
  localparam logic REG_START_WORD = 1'b1;

  // Register reset values.
  localparam logic [7:0]  MAX_BLOCKS_RST = 8'd128;
  localparam logic [15:0] START_WORD_RST = 16'haa55;

  // Previous-word value that pairs with no real word while hunting, unless the start word is 16'hffff.
  localparam logic [15:0] HUNT_RESTART = 16'hffff;

  // Result kinds.
  localparam logic KIND_RECORD    = 1'b0;
  localparam logic KIND_FRAME_END = 1'b1;

  // Frame end reasons.
  localparam logic [1:0] END_NEXT_FRAME = 2'd0;
  localparam logic [1:0] END_ZERO_WORD  = 2'd1;
  localparam logic [1:0] END_NO_SEP     = 2'd2;
  localparam logic [1:0] END_LIMIT      = 2'd3;

  // One result item.
  typedef struct packed {
    logic        result_kind;
    logic [15:0] signature;
    logic [15:0] x_center;
    logic [15:0] y_center;
    logic [15:0] box_width;
    logic [15:0] box_height;
    logic [7:0]  record_count;
    logic [1:0]  end_reason;
  } res_item_t;

endpackage

### hdl/vbfp_front.sv
// ----------------------------------------------------------------------------
// vbfp_front: word classifier and frame parser
// Holds the configuration registers and the parse state, and turns each
// accepted link word into at most one result item in the same cycle.
// ----------------------------------------------------------------------------
module vbfp_front
  import vbfp_pkg::*;
#(
  parameter int RECORD_WORDS = RECORD_WORDS_DEF,
  parameter int MAX_RECORDS  = MAX_RECORDS_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic        cfg_index,
  input  logic [15:0] cfg_wdata,
  input  logic        word_fire,
  input  logic [15:0] word,
  output logic        emit,
  output res_item_t   item
);

  localparam int          IdxW    = (RECORD_WORDS > 1) ? $clog2(RECORD_WORDS) : 1;
  localparam logic [2:0]  LastPos = 3'(RECORD_WORDS - 1);
  localparam logic [7:0]  RecCap  = (MAX_RECORDS > 255) ? 8'd255 : 8'(MAX_RECORDS);

  typedef enum logic [1:0] {PH_HUNT, PH_CHECK, PH_DATA, PH_SEP} phase_t;

  phase_t      phase_r, phase_nxt;
  logic [15:0] prev_r, prev_nxt;
  logic [15:0] exp_sum_r, exp_sum_nxt;
  logic [15:0] run_sum_r, run_sum_nxt;
  logic [2:0]  pos_r, pos_nxt;
  logic [7:0]  count_r, count_nxt;
  logic [7:0]  max_blocks_r;
  logic [15:0] start_word_r;
  logic [15:0] buf_r [RECORD_WORDS];
  logic [15:0] rec_word [5];
  logic [15:0] sum_add;
  logic [7:0]  limit;
  logic        last_pos;

  // Record limit in force: the smaller of the register and the build size.
  assign limit    = (max_blocks_r < RecCap) ? max_blocks_r : RecCap;
  assign sum_add  = run_sum_r + word;
  assign last_pos = (pos_r == LastPos);

  // Record words as reported; the final word comes straight off the link.
  for (genvar j = 0; j < 5; j++) begin : g_word
    if (j < RECORD_WORDS - 1) begin : g_buf
      assign rec_word[j] = buf_r[j];
    end else if (j == RECORD_WORDS - 1) begin : g_last
      assign rec_word[j] = word;
    end else begin : g_none
      assign rec_word[j] = 16'd0;
    end
  end

  // Next state and result item for the current word.
  always_comb begin
    phase_nxt   = phase_r;
    prev_nxt    = prev_r;
    exp_sum_nxt = exp_sum_r;
    run_sum_nxt = run_sum_r;
    pos_nxt     = pos_r;
    count_nxt   = count_r;
    emit        = 1'b0;
    item        = '0;
    item.result_kind  = KIND_FRAME_END;
    item.record_count = count_r;
    case (phase_r)
      PH_HUNT: begin
        if (word == 16'd0 && prev_r == 16'd0) begin
          prev_nxt = HUNT_RESTART;
        end else if (word == start_word_r && prev_r == start_word_r) begin
          prev_nxt  = HUNT_RESTART;
          count_nxt = 8'd0;
          if (limit == 8'd0) begin
            emit              = 1'b1;
            item.record_count = 8'd0;
            item.end_reason   = END_LIMIT;
          end else begin
            phase_nxt = PH_CHECK;
          end
        end else begin
          prev_nxt = word;
        end
      end
      PH_CHECK: begin
        if (word == start_word_r) begin
          emit            = 1'b1;
          item.end_reason = END_NEXT_FRAME;
          count_nxt       = 8'd0;
          phase_nxt       = (limit == 8'd0) ? PH_HUNT : PH_CHECK;
        end else if (word == 16'd0) begin
          emit            = 1'b1;
          item.end_reason = END_ZERO_WORD;
          phase_nxt       = PH_HUNT;
        end else begin
          exp_sum_nxt = word;
          run_sum_nxt = 16'd0;
          pos_nxt     = 3'd0;
          phase_nxt   = PH_DATA;
        end
      end
      PH_DATA: begin
        run_sum_nxt = sum_add;
        pos_nxt     = pos_r + 3'd1;
        if (last_pos) begin
          phase_nxt = PH_SEP;
          pos_nxt   = 3'd0;
          if (sum_add == exp_sum_r) begin
            count_nxt         = count_r + 8'd1;
            emit              = 1'b1;
            item.result_kind  = KIND_RECORD;
            item.signature    = rec_word[0];
            item.x_center     = rec_word[1];
            item.y_center     = rec_word[2];
            item.box_width    = rec_word[3];
            item.box_height   = rec_word[4];
            item.record_count = count_r + 8'd1;
            item.end_reason   = END_NEXT_FRAME;
          end
        end
      end
      PH_SEP: begin
        if (word != start_word_r) begin
          emit            = 1'b1;
          item.end_reason = END_NO_SEP;
          phase_nxt       = PH_HUNT;
        end else if (count_r >= limit) begin
          emit            = 1'b1;
          item.end_reason = END_LIMIT;
          phase_nxt       = PH_HUNT;
        end else begin
          phase_nxt = PH_CHECK;
        end
      end
      default: begin
        phase_nxt = PH_HUNT;
      end
    endcase
    if (!word_fire) begin
      emit = 1'b0;
    end
  end

  // Parse state and configuration registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r      <= PH_HUNT;
      prev_r       <= HUNT_RESTART;
      exp_sum_r    <= 16'd0;
      run_sum_r    <= 16'd0;
      pos_r        <= 3'd0;
      count_r      <= 8'd0;
      max_blocks_r <= MAX_BLOCKS_RST;
      start_word_r <= START_WORD_RST;
    end else begin
      if (word_fire) begin
        phase_r   <= phase_nxt;
        prev_r    <= prev_nxt;
        exp_sum_r <= exp_sum_nxt;
        run_sum_r <= run_sum_nxt;
        pos_r     <= pos_nxt;
        count_r   <= count_nxt;
      end
      if (cfg_we) begin
        case (cfg_index)
          REG_MAX_BLOCKS: max_blocks_r <= cfg_wdata[7:0];
          REG_START_WORD: start_word_r <= cfg_wdata;
          default: ;
        endcase
      end
    end
  end

  // Record word buffer, written in word order while collecting data.
  always_ff @(posedge clk) begin
    if (word_fire && phase_r == PH_DATA) begin
      buf_r[pos_r[IdxW-1:0]] <= word;
    end
  end

  // A record result always carries a nonzero count and no end reason.
  a_record_count: assert property (@(posedge clk) disable iff (!rst_n)
    (emit && item.result_kind == KIND_RECORD) |->
      (item.record_count != 8'd0 && item.end_reason == END_NEXT_FRAME))
    else $error("record result with zero count or an end reason");

  // Data words only follow a checksum word or another data word.
  a_data_entry: assert property (@(posedge clk) disable iff (!rst_n)
    (word_fire && phase_r != PH_DATA && phase_nxt == PH_DATA) |-> phase_r == PH_CHECK)
    else $error("data phase entered from outside the checksum slot");

  // The word position stays inside the record.
  a_pos_range: assert property (@(posedge clk) disable iff (!rst_n)
    pos_r <= LastPos)
    else $error("word position beyond record length");

endmodule

### hdl/vbfp_queue.sv
// ----------------------------------------------------------------------------
// vbfp_queue: result queue and output stage
// A short register queue between the parser and the result channel; its
// head entry drives the result beat.
// ----------------------------------------------------------------------------
module vbfp_queue
  import vbfp_pkg::*;
#(
  parameter int DEPTH = QUEUE_DEPTH
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      push,
  input  res_item_t push_item,
  output logic      full,
  output logic      head_valid,
  input  logic      pop,
  output res_item_t head_item
);

  localparam int PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CntW = $clog2(DEPTH + 1);

  res_item_t         mem_r [DEPTH];
  logic [PtrW-1:0]   wr_ptr_r, wr_ptr_nxt;
  logic [PtrW-1:0]   rd_ptr_r, rd_ptr_nxt;
  logic [CntW-1:0]   cnt_r, cnt_nxt;
  logic              do_push, do_pop;

  assign full       = (cnt_r == CntW'(DEPTH));
  assign head_valid = (cnt_r != '0);
  assign head_item  = mem_r[rd_ptr_r];
  assign do_push    = push && !full;
  assign do_pop     = pop && head_valid;

  // Pointer and fill count updates, with wrap at the queue depth.
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == PtrW'(DEPTH - 1)) ? '0 : wr_ptr_r + PtrW'(1);
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PtrW'(DEPTH - 1)) ? '0 : rd_ptr_r + PtrW'(1);
    end
    if (do_push && !do_pop) begin
      cnt_nxt = cnt_r + CntW'(1);
    end else if (do_pop && !do_push) begin
      cnt_nxt = cnt_r - CntW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  // Entry storage.
  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_item;
    end
  end

  // The parser never offers an item the queue cannot take.
  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    push |-> !full)
    else $error("result pushed into a full queue");

  // A lone pop shrinks the fill count by one.
  a_pop_count: assert property (@(posedge clk) disable iff (!rst_n)
    (do_pop && !do_push) |=> cnt_r == $past(cnt_r) - CntW'(1))
    else $error("fill count wrong after pop");

  // A lone push lands at the tail and becomes visible in the next cycle.
  a_push_count: assert property (@(posedge clk) disable iff (!rst_n)
    (do_push && !do_pop) |=> (head_valid && cnt_r == $past(cnt_r) + CntW'(1)))
    else $error("fill count wrong after push");

endmodule

### hdl/vision_block_frame_parser_unit.sv
// ----------------------------------------------------------------------------
// vision_block_frame_parser_unit: framed, checksummed record parser
// Hunts for frames on a 16-bit camera link, checks each record's checksum
// and reports good records and frame ends.
//
//   Channel  Dir  Beat contents
//   in_      in   tdata[15:0] data_word
//   out_     out  tuser result_kind; tdata record words, count, end reason
//   cfg_     in   index 0 max_blocks, index 1 start_word
//
// One link word per cycle is sustained while the result queue has room. A
// word is parsed in the cycle it is accepted; its result, if any, enters the
// queue and reaches the output once earlier results are taken. The
// next parser state and the 16-bit checksum add are combinational. A two-entry
// result queue lets the output stall on its own; in_tready drops only while it is full.
// Reset is synchronous; there is no clearing pass after it.
// ----------------------------------------------------------------------------
module vision_block_frame_parser_unit
  import vbfp_pkg::*;
#(
  parameter int RECORD_WORDS = RECORD_WORDS_DEF,
  parameter int MAX_RECORDS  = MAX_RECORDS_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  // Link words.
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [15:0] in_tdata,   // [15:0] data_word
  // Results.
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [95:0] out_tdata,  // signature, x_center, y_center, box_width,
                                  // box_height, record_count[7:0],
                                  // end_reason[1:0], zero fill
  output logic        out_tuser,  // result_kind
  // Configuration writes.
  input  logic        cfg_we,
  input  logic        cfg_index,
  input  logic [15:0] cfg_wdata
);

  logic      q_full;
  logic      word_fire;
  logic      emit;
  res_item_t item;
  res_item_t head;

  assign in_tready = !q_full;
  assign word_fire = in_tvalid && in_tready;

  // Front part: parse each accepted word.
  vbfp_front #(
    .RECORD_WORDS (RECORD_WORDS),
    .MAX_RECORDS  (MAX_RECORDS)
  ) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .word_fire (word_fire),
    .word      (in_tdata),
    .emit      (emit),
    .item      (item)
  );

  // Back part: queue results and present the head beat.
  vbfp_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (emit),
    .push_item  (item),
    .full       (q_full),
    .head_valid (out_tvalid),
    .pop        (out_tready),
    .head_item  (head)
  );

  // Result beat packing.
  assign out_tuser = head.result_kind;
  assign out_tdata = {6'd0, head.end_reason, head.record_count, head.box_height,
                      head.box_width, head.y_center, head.x_center,
                      head.signature};

endmodule

### test/vision_block_frame_parser_unit_test.sv
// ----------------------------------------------------------------------------
// vision_block_frame_parser_unit_test: self-checking bench for the frame parser
// Feeds link words through the input stream with random gaps, stalls the
// result stream at random and compares every result beat, field by field,
// with a behavioral copy of the parser kept inside the bench. A short
// table of directed words comes first, then register phases of framed
// random traffic, including a full-length frame that runs into the limit.
// ----------------------------------------------------------------------------
module vision_block_frame_parser_unit_test;
  timeunit 1ns;
  timeprecision 1ps;

  import vbfp_pkg::*;

  localparam int NWORDS       = RECORD_WORDS_DEF;
  localparam int DRAIN_CYCLES = 6;

  typedef enum logic [1:0] {LK_HUNT, LK_CHECKSUM, LK_DATA, LK_SEPARATOR} link_phase_t;
  typedef enum logic {ROW_WORD, ROW_REG} row_op_t;

  // One row of the directed table: a link word or a register write.
  typedef struct {
    row_op_t     op;
    logic        reg_sel;
    logic [15:0] value;
    logic        typed;
    res_item_t   want;
  } stim_row_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [15:0] in_tdata = '0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [95:0] out_tdata;
  logic        out_tuser;
  logic        cfg_we = 1'b0;
  logic        cfg_index = 1'b0;
  logic [15:0] cfg_wdata = '0;

  // Bench copy of the parser state and its registers.
  link_phase_t lk_phase;
  logic [15:0] lk_prev;
  logic [15:0] lk_want_sum;
  logic [15:0] lk_sum;
  logic [2:0]  lk_pos;
  logic [7:0]  lk_count;
  logic [15:0] lk_buf [NWORDS];
  logic [7:0]  lk_max_blocks;
  logic [15:0] lk_start;

  res_item_t   pending_results[$];
  res_item_t   oldest_result;
  stim_row_t   dir_rows[$];
  int          fail_count = 0;
  int unsigned words_sent = 0;
  bit          gaps_on = 1'b1;

  vision_block_frame_parser_unit dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tuser (out_tuser),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  always #5 clk = ~clk;

  // Records per frame in force; the register is clamped to the build size.
  function automatic logic [7:0] record_limit();
    return (lk_max_blocks > MAX_RECORDS_DEF) ? 8'(MAX_RECORDS_DEF) : lk_max_blocks;
  endfunction

  function automatic res_item_t make_end(logic [7:0] count, logic [1:0] reason);
    res_item_t r;
    r = '0;
    r.result_kind  = KIND_FRAME_END;
    r.record_count = count;
    r.end_reason   = reason;
    return r;
  endfunction

  function automatic res_item_t make_record(logic [15:0] s, logic [15:0] x, logic [15:0] y,
                                            logic [15:0] w, logic [15:0] h, logic [7:0] count);
    res_item_t r;
    r = '0;
    r.result_kind  = KIND_RECORD;
    r.signature    = s;
    r.x_center     = x;
    r.y_center     = y;
    r.box_width    = w;
    r.box_height   = h;
    r.record_count = count;
    return r;
  endfunction

  // Advances the bench parser by one link word; returns 1 when a result is due.
  function automatic bit parse_link_word(input logic [15:0] w, output res_item_t r);
    r = '0;
    case (lk_phase)
      LK_HUNT: begin
        if (w == 16'h0000 && lk_prev == 16'h0000) begin
          // Two zero words: the link is idle, hunting starts over.
          lk_prev = HUNT_RESTART;
        end else if (w == lk_start && lk_prev == lk_start) begin
          lk_prev  = HUNT_RESTART;
          lk_count = '0;
          if (record_limit() == 8'd0) begin
            r = make_end(8'd0, END_LIMIT);
            return 1'b1;
          end
          lk_phase = LK_CHECKSUM;
        end else begin
          lk_prev = w;
        end
      end
      LK_CHECKSUM: begin
        if (w == lk_start) begin
          // A start word here closes the frame and opens the next one.
          r = make_end(lk_count, END_NEXT_FRAME);
          lk_count = '0;
          lk_phase = (record_limit() == 8'd0) ? LK_HUNT : LK_CHECKSUM;
          return 1'b1;
        end else if (w == 16'h0000) begin
          lk_phase = LK_HUNT;
          r = make_end(lk_count, END_ZERO_WORD);
          return 1'b1;
        end
        lk_want_sum = w;
        lk_sum      = '0;
        lk_pos      = '0;
        lk_phase    = LK_DATA;
      end
      LK_DATA: begin
        lk_buf[lk_pos] = w;
        lk_sum = lk_sum + w;
        lk_pos = lk_pos + 3'd1;
        if (lk_pos == 3'(NWORDS)) begin
          lk_phase = LK_SEPARATOR;
          lk_pos   = '0;
          if (lk_sum == lk_want_sum) begin
            lk_count = lk_count + 8'd1;
            r = make_record(lk_buf[0], lk_buf[1], lk_buf[2], lk_buf[3], lk_buf[4], lk_count);
            return 1'b1;
          end
        end
      end
      default: begin
        if (w != lk_start) begin
          lk_phase = LK_HUNT;
          r = make_end(lk_count, END_NO_SEP);
          return 1'b1;
        end else if (lk_count >= record_limit()) begin
          lk_phase = LK_HUNT;
          r = make_end(lk_count, END_LIMIT);
          return 1'b1;
        end
        lk_phase = LK_CHECKSUM;
      end
    endcase
    return 1'b0;
  endfunction

  // Presents one word and holds it until a beat is taken; a typed
  // expectation replaces the predicted one.
  task automatic push_word(input logic [15:0] w, input logic typed = 1'b0,
                           input res_item_t want = '0);
    logic      took;
    res_item_t r;
    bit        got;
    while (gaps_on && $urandom_range(0, 99) < 13) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= w;
    took = 1'b0;
    while (!took) begin
      @(negedge clk);
      took = in_tready;
      @(posedge clk);
    end
    words_sent++;
    got = parse_link_word(w, r);
    if (typed) begin
      pending_results.push_back(want);
    end else if (got) begin
      pending_results.push_back(r);
    end
  endtask

  // Drops valid and lets every outstanding result drain.
  task automatic wait_idle();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic sel, input logic [15:0] data);
    wait_idle();
    cfg_we    <= 1'b1;
    cfg_index <= sel;
    cfg_wdata <= data;
    @(posedge clk);
    cfg_we <= 1'b0;
    if (sel == REG_MAX_BLOCKS) begin
      lk_max_blocks = data[7:0];
    end else begin
      lk_start = data;
    end
  endtask

  // Data words lean toward the corner values and the start word.
  function automatic logic [15:0] rand_word();
    case ($urandom_range(0, 9))
      0: return 16'h0000;
      1: return 16'hffff;
      2: return lk_start;
      default: return 16'($urandom);
    endcase
  endfunction

  // Walks the parser into a frame, waiting for a checksum word.
  task automatic steer_into_frame();
    while (lk_phase != LK_CHECKSUM) begin
      push_word((lk_phase == LK_DATA) ? 16'($urandom) : lk_start);
    end
  endtask

  // Sync pair, then records; unless clean, checksums and separators may break
  // and the frame may close on a start word or a zero word.
  task automatic gen_frame(input int n_rec, input bit clean);
    logic [15:0] d [NWORDS];
    logic [15:0] sum;
    int          k;
    int          j;
    push_word(lk_start);
    push_word(lk_start);
    for (k = 0; k < n_rec; k++) begin
      sum = '0;
      for (j = 0; j < NWORDS; j++) begin
        d[j] = rand_word();
        sum  = sum + d[j];
      end
      if (!clean && $urandom_range(0, 99) < 15) begin
        push_word(sum ^ 16'($urandom_range(1, 65535)));
      end else begin
        push_word(sum);
      end
      for (j = 0; j < NWORDS; j++) push_word(d[j]);
      if (!clean && $urandom_range(0, 99) < 5) begin
        push_word(lk_start ^ 16'($urandom_range(1, 65535)));
        return;
      end
      push_word(lk_start);
    end
    if (!clean) begin
      case ($urandom_range(0, 2))
        1: push_word(lk_start);
        2: push_word(16'h0000);
        default: ;
      endcase
    end
  endtask

  task automatic check_field(input string name, input logic [15:0] want,
                             input logic [15:0] seen);
    if (want !== seen) begin
      $error("%s: expected %h, got %h", name, want, seen);
      fail_count++;
    end
  endtask

  // Result side stalls at random while gaps are enabled.
  always @(posedge clk) begin
    out_tready <= !(gaps_on && ($urandom_range(0, 99) < 13));
  end

  // A result beat seen at the falling edge is taken at the next rising edge.
  always @(negedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      if (pending_results.size() == 0) begin
        $error("result beat with nothing expected: tuser %b tdata %h", out_tuser, out_tdata);
        fail_count++;
      end else begin
        oldest_result = pending_results.pop_front();
        check_field("result_kind", 16'(oldest_result.result_kind), 16'(out_tuser));
        check_field("signature", oldest_result.signature, out_tdata[15:0]);
        check_field("x_center", oldest_result.x_center, out_tdata[31:16]);
        check_field("y_center", oldest_result.y_center, out_tdata[47:32]);
        check_field("box_width", oldest_result.box_width, out_tdata[63:48]);
        check_field("box_height", oldest_result.box_height, out_tdata[79:64]);
        check_field("record_count", 16'(oldest_result.record_count), 16'(out_tdata[87:80]));
        check_field("end_reason", 16'(oldest_result.end_reason), 16'(out_tdata[89:88]));
      end
    end
  end

  initial begin
    #5_000_000;
    $display("tb: failure");
    $finish;
  end

  initial begin
    int unsigned ph_words [9];
    logic [7:0]  ph_mb [9];
    logic [15:0] ph_sw [9];
    logic [7:0]  hi;
    int unsigned first;
    int          p;
    int          n;

    // Parser state after reset.
    lk_phase      = LK_HUNT;
    lk_prev       = HUNT_RESTART;
    lk_want_sum   = '0;
    lk_sum        = '0;
    lk_pos        = '0;
    lk_count      = '0;
    lk_max_blocks = MAX_BLOCKS_RST;
    lk_start      = START_WORD_RST;
    foreach (lk_buf[i]) lk_buf[i] = '0;

    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed table: idle pair, zero close, start-word close, a full-scale
    // record hitting a limit of one, a dropped record with a bad separator,
    // and a frame opened while the limit is zero.
    dir_rows.push_back('{ROW_REG, REG_MAX_BLOCKS, 16'hff01, 1'b0, '0});
    dir_rows.push_back('{ROW_WORD, 1'b0, 16'h0000, 1'b0, '0});
    dir_rows.push_back('{ROW_WORD, 1'b0, 16'h0000, 1'b0, '0});
    dir_rows.push_back('{ROW_WORD, 1'b0, START_WORD_RST, 1'b0, '0});
    dir_rows.push_back('{ROW_WORD, 1'b0, START_WORD_RST, 1'b0, '0});
    dir_rows.push_back('{ROW_WORD, 1'b0, 16'h0000, 1'b1, make_end(8'd0, END_ZERO_WORD)});
    dir_rows.push_back('{ROW_WORD, 1'b0, START_WORD_RST, 1'b0, '0});
    dir_rows.push_back('{ROW_WORD, 1'b0, START_WORD_RST, 1'b0, '0});
    dir_rows.push_back('{ROW_WORD, 1'b0, START_WORD_RST, 1'b1,
                         make_end(8'd0, END_NEXT_FRAME)});
    dir_rows.push_back('{ROW_WORD, 1'b0, 16'hfffb, 1'b0, '0});
    dir_rows.push_back('{ROW_WORD, 1'b0, 16'hffff, 1'b0, '0});
    dir_rows.push_back('{ROW_WORD, 1'b0, 16'hffff, 1'b0, '0});
    dir_rows.push_back('{ROW_WORD, 1'b0, 16'hffff, 1'b0, '0});
    dir_rows.push_back('{ROW_WORD, 1'b0, 16'hffff, 1'b0, '0});
    dir_rows.push_back('{ROW_WORD, 1'b0, 16'hffff, 1'b1,
                         make_record(16'hffff, 16'hffff, 16'hffff, 16'hffff, 16'hffff, 8'd1)});
    dir_rows.push_back('{ROW_WORD, 1'b0, START_WORD_RST, 1'b1, make_end(8'd1, END_LIMIT)});
    dir_rows.push_back('{ROW_REG, REG_MAX_BLOCKS, 16'h0080, 1'b0, '0});
    dir_rows.push_back('{ROW_WORD, 1'b0, START_WORD_RST, 1'b0, '0});
    dir_rows.push_back('{ROW_WORD, 1'b0, START_WORD_RST, 1'b0, '0});
    dir_rows.push_back('{ROW_WORD, 1'b0, 16'h0002, 1'b0, '0});
    dir_rows.push_back('{ROW_WORD, 1'b0, 16'h0000, 1'b0, '0});
    dir_rows.push_back('{ROW_WORD, 1'b0, 16'h0000, 1'b0, '0});
    dir_rows.push_back('{ROW_WORD, 1'b0, 16'h0000, 1'b0, '0});
    dir_rows.push_back('{ROW_WORD, 1'b0, 16'h0000, 1'b0, '0});
    dir_rows.push_back('{ROW_WORD, 1'b0, 16'h0001, 1'b0, '0});
    dir_rows.push_back('{ROW_WORD, 1'b0, 16'h1111, 1'b1, make_end(8'd0, END_NO_SEP)});
    dir_rows.push_back('{ROW_REG, REG_MAX_BLOCKS, 16'h0000, 1'b0, '0});
    dir_rows.push_back('{ROW_WORD, 1'b0, START_WORD_RST, 1'b0, '0});
    dir_rows.push_back('{ROW_WORD, 1'b0, START_WORD_RST, 1'b1, make_end(8'd0, END_LIMIT)});

    foreach (dir_rows[i]) begin
      if (dir_rows[i].op == ROW_REG) begin
        write_reg(dir_rows[i].reg_sel, dir_rows[i].value);
      end else begin
        push_word(dir_rows[i].value, dir_rows[i].typed, dir_rows[i].want);
      end
    end

    // Register phases: zero start word, all-ones start word, zero limit,
    // clamped limit with one full-length frame, a phase with no gaps at all.
    ph_words = '{16, 16, 16, 16, 0, 16, 120, 16, 16};
    ph_mb    = '{8'd128, 8'd1, 8'd255, 8'd0, 8'd255, 8'd3, 8'd2,
                 8'($urandom_range(0, 255)), 8'd128};
    ph_sw    = '{16'haa55, 16'h0000, 16'hffff, 16'haa55, 16'haa55, 16'($urandom),
                 16'h8001, 16'($urandom), 16'haa55};

    for (p = 0; p < 9; p++) begin
      hi = 8'($urandom_range(0, 255));
      write_reg(REG_MAX_BLOCKS, {hi, ph_mb[p]});
      write_reg(REG_START_WORD, ph_sw[p]);
      gaps_on = (p != 6);
      first = words_sent;
      if (p == 4) begin
        steer_into_frame();
        gen_frame(MAX_RECORDS_DEF, 1'b1);
      end
      while (words_sent - first < ph_words[p]) begin
        n = $urandom_range(0, 99);
        if (n < 70) begin
          gen_frame($urandom_range(0, 4), 1'b0);
        end else if (n < 85) begin
          repeat ($urandom_range(1, 6)) push_word(rand_word());
        end else begin
          push_word(16'h0000);
          push_word(16'h0000);
        end
      end
      // Leave the parser inside a frame so the next register change meets it there.
      if (lk_start != 16'h0000 && record_limit() != 8'd0) begin
        steer_into_frame();
      end
    end

    gaps_on = 1'b1;
    wait_idle();
    if (fail_count == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
